>>> src/cdup_pkg.sv
// Shared types, codes and helpers for the class-data ULEB128 parser.
// No dependencies; used by the parser top level.
package cdup_pkg;

  localparam int unsigned ValW = 32;

  // Parser phase: header counts, then the four member lists, then finished.
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_STATIC   = 3'd1,
    PH_INSTANCE = 3'd2,
    PH_DIRECT   = 3'd3,
    PH_VIRTUAL  = 3'd4,
    PH_DONE     = 3'd5
  } phase_e;

  // Header sub-steps count 0..3; member sub-steps are delta, flags, code offset.
  localparam logic [1:0] SubDelta = 2'd0;
  localparam logic [1:0] SubFlags = 2'd1;
  localparam logic [1:0] SubCode  = 2'd2;
  localparam logic [1:0] SubLastCount = 2'd3;

  localparam logic [2:0] MaxLebBytes = 3'd4;  // byte index of the closing fifth byte

  typedef logic [3:0][ValW-1:0] counts_t;

  typedef struct packed {
    phase_e          phase;
    logic [ValW-1:0] members;
  } list_sel_t;

  typedef struct packed {
    logic [2:0]      entry_kind;
    logic [ValW-1:0] static_count;
    logic [ValW-1:0] instance_count;
    logic [ValW-1:0] direct_count;
    logic [ValW-1:0] virtual_count;
    logic [ValW-1:0] member_index;
    logic [ValW-1:0] access_flags;
    logic [ValW-1:0] code_addr;
    logic            has_code;
    logic            record_last;
  } out_item_t;

  // Pick the first list at or after list number first that holds members.
  function automatic list_sel_t enter_list(input counts_t counts, input logic [2:0] first);
    list_sel_t sel;
    logic      found;
    sel.phase   = PH_DONE;
    sel.members = '0;
    found       = 1'b0;
    for (int k = 1; k <= 4; k++) begin
      if (!found && (3'(k) >= first) && (counts[2'(k - 1)] != '0)) begin
        sel.phase   = phase_e'(3'(k));
        sel.members = counts[2'(k - 1)];
        found       = 1'b1;
      end
    end
    return sel;
  endfunction

endpackage

>>> src/cdup_in_if.sv
// Byte input channel of the class-data parser: valid/ready plus byte payload.
// No dependencies.
interface cdup_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       record_start;

  modport source (output valid, output data_byte, output record_start, input ready);
  modport sink   (input valid, input data_byte, input record_start, output ready);
endinterface

>>> src/cdup_out_if.sv
// Result channel of the class-data parser: valid/ready plus one decoded entry.
// No dependencies.
interface cdup_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  entry_kind;
  logic [31:0] static_count;
  logic [31:0] instance_count;
  logic [31:0] direct_count;
  logic [31:0] virtual_count;
  logic [31:0] member_index;
  logic [31:0] access_flags;
  logic [31:0] code_addr;
  logic        has_code;
  logic        record_last;

  modport source (
    output valid, output entry_kind, output static_count, output instance_count,
    output direct_count, output virtual_count, output member_index,
    output access_flags, output code_addr, output has_code, output record_last,
    input ready
  );
  modport sink (
    input valid, input entry_kind, input static_count, input instance_count,
    input direct_count, input virtual_count, input member_index,
    input access_flags, input code_addr, input has_code, input record_last,
    output ready
  );
endinterface

>>> src/class_data_uleb128_parser.sv
// Class-data record parser: byte-wise ULEB128 decode and member list walk.
// Depends on cdup_pkg, cdup_in_if and cdup_out_if.
//
// Usage:
//   in_i carries one record byte per transfer; record_start marks the first
//   byte of a record and restarts the parser even in the middle of a value.
//   out_o carries one decoded entry per transfer: a header with the four
//   list counts, then one entry per static field, instance field, direct
//   method and virtual method. record_last flags the final entry; bytes
//   after it are consumed without results until the next record_start.
//   A byte that closes an entry has its result registered in the result
//   register, or in the skid register while out_o stalls. Throughput: one
//   byte per cycle while in_i is ready; the decode, index add and list
//   selection all sit between the state registers and the result register.
//   Stall: a two-entry output buffer (result register plus skid register)
//   keeps in_i ready while one result waits; in_i drops ready only while
//   the skid register is full.
//   Reset (rst_ni low) returns the parser to the first header count and
//   empties the output buffer.
module class_data_uleb128_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  cdup_in_if.sink         in_i,
  cdup_out_if.source      out_o
);

  localparam int unsigned W = cdup_pkg::ValW;

  cdup_pkg::phase_e    phase_q, phase_d, cur_phase;
  logic [1:0]          sub_q, sub_d, cur_sub;
  logic [W-1:0]        acc_q, acc_d, cur_acc;
  logic [2:0]          bc_q, bc_d, cur_bc;
  cdup_pkg::counts_t   counts_q, counts_d, hdr_counts;
  logic [W-1:0]        left_q, left_d, left_dec;
  logic [W-1:0]        index_q, index_d;
  logic [W-1:0]        held_q, held_d;

  cdup_pkg::out_item_t out_q, skid_q, res;
  logic                out_valid_q, skid_valid_q;

  logic                in_fire, out_fire, emit, done, is_method;
  logic [W-1:0]        shifted, val;
  cdup_pkg::list_sel_t sel_hdr, sel_next;

  assign in_i.ready = !skid_valid_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_fire   = out_valid_q && out_o.ready;

  // A restart byte sees the post-reset decode state.
  assign cur_phase = in_i.record_start ? cdup_pkg::PH_HEADER : phase_q;
  assign cur_sub   = in_i.record_start ? 2'd0 : sub_q;
  assign cur_acc   = in_i.record_start ? '0 : acc_q;
  assign cur_bc    = in_i.record_start ? 3'd0 : bc_q;

  always_comb begin
    unique case (cur_bc)
      3'd0:    shifted = {25'd0, in_i.data_byte[6:0]};
      3'd1:    shifted = {18'd0, in_i.data_byte[6:0], 7'd0};
      3'd2:    shifted = {11'd0, in_i.data_byte[6:0], 14'd0};
      3'd3:    shifted = {4'd0, in_i.data_byte[6:0], 21'd0};
      default: shifted = {in_i.data_byte[3:0], 28'd0};
    endcase
  end

  assign val  = cur_acc | shifted;
  assign done = (cur_bc >= cdup_pkg::MaxLebBytes) || !in_i.data_byte[7];

  assign hdr_counts = {val, counts_q[2], counts_q[1], counts_q[0]};
  assign sel_hdr    = cdup_pkg::enter_list(hdr_counts, 3'd1);
  assign sel_next   = cdup_pkg::enter_list(counts_q, 3'(phase_q) + 3'd1);
  assign left_dec   = left_q - W'(1);
  assign is_method  = (cur_phase == cdup_pkg::PH_DIRECT) || (cur_phase == cdup_pkg::PH_VIRTUAL);

  always_comb begin
    phase_d  = phase_q;
    sub_d    = sub_q;
    acc_d    = acc_q;
    bc_d     = bc_q;
    counts_d = counts_q;
    left_d   = left_q;
    index_d  = index_q;
    held_d   = held_q;
    emit     = 1'b0;
    res      = '0;
    if (in_fire) begin
      phase_d = cur_phase;
      sub_d   = cur_sub;
      acc_d   = cur_acc;
      bc_d    = cur_bc;
      if (cur_phase != cdup_pkg::PH_DONE) begin
        if (!done) begin
          acc_d = val;
          bc_d  = cur_bc + 3'd1;
        end else begin
          acc_d = '0;
          bc_d  = 3'd0;
          if (cur_phase == cdup_pkg::PH_HEADER) begin
            counts_d[cur_sub] = val;
            if (cur_sub != cdup_pkg::SubLastCount) begin
              sub_d = cur_sub + 2'd1;
            end else begin
              emit               = 1'b1;
              res.entry_kind     = 3'(cdup_pkg::PH_HEADER);
              res.static_count   = hdr_counts[0];
              res.instance_count = hdr_counts[1];
              res.direct_count   = hdr_counts[2];
              res.virtual_count  = hdr_counts[3];
              res.record_last    = (sel_hdr.phase == cdup_pkg::PH_DONE);
              phase_d            = sel_hdr.phase;
              left_d             = sel_hdr.members;
              sub_d              = cdup_pkg::SubDelta;
              index_d            = '0;
            end
          end else if (cur_sub == cdup_pkg::SubDelta) begin
            index_d = index_q + val;
            sub_d   = cdup_pkg::SubFlags;
          end else if ((cur_sub == cdup_pkg::SubFlags) && is_method) begin
            held_d = val;
            sub_d  = cdup_pkg::SubCode;
          end else begin
            emit             = 1'b1;
            res.entry_kind   = 3'(cur_phase);
            res.member_index = index_q;
            if (is_method) begin
              res.access_flags = held_q;
              res.code_addr    = val;
              res.has_code     = |val;
            end else begin
              res.access_flags = val;
            end
            sub_d = cdup_pkg::SubDelta;
            if (left_dec == '0) begin
              // advance to the next non-empty list, or finish the record
              res.record_last = (sel_next.phase == cdup_pkg::PH_DONE);
              phase_d         = sel_next.phase;
              left_d          = sel_next.members;
              index_d         = '0;
            end else begin
              left_d = left_dec;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cdup_pkg::PH_HEADER;
      sub_q    <= 2'd0;
      acc_q    <= '0;
      bc_q     <= 3'd0;
      counts_q <= '0;
      left_q   <= '0;
      index_q  <= '0;
      held_q   <= '0;
    end else begin
      phase_q  <= phase_d;
      sub_q    <= sub_d;
      acc_q    <= acc_d;
      bc_q     <= bc_d;
      counts_q <= counts_d;
      left_q   <= left_d;
      index_q  <= index_d;
      held_q   <= held_d;
    end
  end

  // Output register with skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (emit) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.entry_kind     = out_q.entry_kind;
  assign out_o.static_count   = out_q.static_count;
  assign out_o.instance_count = out_q.instance_count;
  assign out_o.direct_count   = out_q.direct_count;
  assign out_o.virtual_count  = out_q.virtual_count;
  assign out_o.member_index   = out_q.member_index;
  assign out_o.access_flags   = out_q.access_flags;
  assign out_o.code_addr      = out_q.code_addr;
  assign out_o.has_code       = out_q.has_code;
  assign out_o.record_last    = out_q.record_last;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a result in the output register");

  a_leb_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= cdup_pkg::MaxLebBytes)
    else $error("value byte count past the fifth byte");

  a_list_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != cdup_pkg::PH_HEADER && phase_q != cdup_pkg::PH_DONE) |-> (left_q != '0))
    else $error("member list entered with no members left");

  a_code_only_methods: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != cdup_pkg::PH_HEADER && sub_q == cdup_pkg::SubCode) |->
      (phase_q == cdup_pkg::PH_DIRECT || phase_q == cdup_pkg::PH_VIRTUAL))
    else $error("code offset step outside a method list");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == cdup_pkg::PH_DONE && !in_i.record_start) |-> !emit)
    else $error("result produced after the end of a record");
`endif

endmodule
